[hdl/i2c_register_access_master_defines.svh]
// ----------------------------------------------------------------------------
// I2C register access master: assertion macros
// Shared concurrent assertion forms used by the RTL of this block.
// ----------------------------------------------------------------------------
`ifndef I2C_REGISTER_ACCESS_MASTER_DEFINES_SVH
`define I2C_REGISTER_ACCESS_MASTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2CRA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("i2cra assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define I2CRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("i2cra assertion failed");

`endif

[hdl/i2cra_pkg.sv]
// ----------------------------------------------------------------------------
// I2C register access master: package
// Request and result types, opcodes and sequencer phases.
// ----------------------------------------------------------------------------
package i2cra_pkg;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [7:0] ACK_POLL_LIMIT_RESET = 8'd255;
    localparam logic [3:0] BITS_PER_BYTE        = 4'd8;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'd0,
        PH_ST_SDA    = 5'd1,
        PH_ST_SCL    = 5'd2,
        PH_D0_LOW    = 5'd3,
        PH_D0_HIGH   = 5'd4,
        PH_D0_WAIT   = 5'd5,
        PH_R_LOW     = 5'd6,
        PH_R_HIGH    = 5'd7,
        PH_R_WAIT    = 5'd8,
        PH_W_LOW     = 5'd9,
        PH_W_HIGH    = 5'd10,
        PH_W_WAIT    = 5'd11,
        PH_RS_HIGH   = 5'd12,
        PH_RS_SDA    = 5'd13,
        PH_RS_SCL    = 5'd14,
        PH_D1_LOW    = 5'd15,
        PH_D1_HIGH   = 5'd16,
        PH_D1_WAIT   = 5'd17,
        PH_RD_PREP   = 5'd18,
        PH_RD_HIGH   = 5'd19,
        PH_RD_SAMPLE = 5'd20,
        PH_NACK_HIGH = 5'd21,
        PH_NACK_LOW  = 5'd22,
        PH_SP_LOW    = 5'd23,
        PH_SP_SCL    = 5'd24,
        PH_SP_SDA    = 5'd25
    } phase_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] device_byte;
        logic [7:0] register_address;
        logic [7:0] write_data;
        logic       sda_level;
    } in_item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
    } out_item_t;

    // Request handed from the input side to the sequencer.
    typedef struct packed {
        logic       accept;
        logic [7:0] ack_poll_limit;
    } seq_ctrl_t;

endpackage

[hdl/i2cra_seq.sv]
// ----------------------------------------------------------------------------
// I2C register access master: sequencer
// Holds the bus state and computes one step per accepted request.
// ----------------------------------------------------------------------------
module i2cra_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  i2cra_pkg::seq_ctrl_t ctrl,
    input  i2cra_pkg::in_item_t  item,
    output i2cra_pkg::out_item_t result
);
    import i2cra_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [3:0] bit_count_reg, bit_count_next;
    logic [7:0] shift_byte_reg, shift_byte_next;
    logic       cmd_read_reg, cmd_read_next;
    logic [7:0] cmd_device_reg, cmd_device_next;
    logic [7:0] cmd_register_reg, cmd_register_next;
    logic [7:0] cmd_data_reg, cmd_data_next;
    logic [7:0] poll_count_reg, poll_count_next;
    logic [7:0] received_reg, received_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       done;
    logic       ack_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            bit_count_reg    <= '0;
            shift_byte_reg   <= '0;
            cmd_read_reg     <= 1'b0;
            cmd_device_reg   <= '0;
            cmd_register_reg <= '0;
            cmd_data_reg     <= '0;
            poll_count_reg   <= '0;
            received_reg     <= '0;
            scl_reg          <= 1'b1;
            sda_reg          <= 1'b1;
        end else begin
            phase_reg        <= phase_next;
            bit_count_reg    <= bit_count_next;
            shift_byte_reg   <= shift_byte_next;
            cmd_read_reg     <= cmd_read_next;
            cmd_device_reg   <= cmd_device_next;
            cmd_register_reg <= cmd_register_next;
            cmd_data_reg     <= cmd_data_next;
            poll_count_reg   <= poll_count_next;
            received_reg     <= received_next;
            scl_reg          <= scl_next;
            sda_reg          <= sda_next;
        end
    end

    // An acknowledge slot ends on a low SDA or once the poll limit is reached.
    assign ack_done = !item.sda_level || (poll_count_reg >= ctrl.ack_poll_limit);

    always_comb begin
        phase_next        = phase_reg;
        bit_count_next    = bit_count_reg;
        shift_byte_next   = shift_byte_reg;
        cmd_read_next     = cmd_read_reg;
        cmd_device_next   = cmd_device_reg;
        cmd_register_next = cmd_register_reg;
        cmd_data_next     = cmd_data_reg;
        poll_count_next   = poll_count_reg;
        received_next     = received_reg;
        scl_next          = scl_reg;
        sda_next          = sda_reg;
        done              = 1'b0;

        if (ctrl.accept && item.opcode == OP_TICK) begin
            unique case (phase_reg) inside
                PH_ST_SDA: begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b0;
                    phase_next = PH_ST_SCL;
                end
                PH_ST_SCL: begin
                    scl_next        = 1'b0;
                    sda_next        = 1'b0;
                    shift_byte_next = cmd_device_reg;
                    bit_count_next  = '0;
                    phase_next      = PH_D0_LOW;
                end
                // Low half of a data bit, or SDA release before the acknowledge.
                PH_D0_LOW, PH_R_LOW, PH_W_LOW, PH_D1_LOW: begin
                    scl_next = 1'b0;
                    if (bit_count_reg < BITS_PER_BYTE) begin
                        sda_next        = shift_byte_reg[7];
                        shift_byte_next = {shift_byte_reg[6:0], 1'b0};
                    end else begin
                        sda_next = 1'b1;
                    end
                    phase_next = phase_t'(phase_reg + 5'd1);
                end
                // High phases sit between their low and wait phases.
                PH_D0_HIGH, PH_R_HIGH, PH_W_HIGH, PH_D1_HIGH: begin
                    scl_next = 1'b1;
                    if (bit_count_reg < BITS_PER_BYTE) begin
                        bit_count_next = bit_count_reg + 4'd1;
                        phase_next     = phase_t'(phase_reg - 5'd1);
                    end else begin
                        poll_count_next = '0;
                        phase_next      = phase_t'(phase_reg + 5'd1);
                    end
                end
                PH_D0_WAIT, PH_R_WAIT, PH_W_WAIT, PH_D1_WAIT: begin
                    if (!ack_done) begin
                        poll_count_next = poll_count_reg + 8'd1;
                        scl_next        = 1'b1;
                    end else begin
                        poll_count_next = '0;
                        scl_next        = 1'b0;
                        unique case (phase_reg) inside
                            PH_D0_WAIT: begin
                                shift_byte_next = cmd_register_reg;
                                bit_count_next  = '0;
                                phase_next      = PH_R_LOW;
                            end
                            PH_R_WAIT: begin
                                if (cmd_read_reg) begin
                                    phase_next = PH_RS_HIGH;
                                end else begin
                                    shift_byte_next = cmd_data_reg;
                                    bit_count_next  = '0;
                                    phase_next      = PH_W_LOW;
                                end
                            end
                            PH_W_WAIT: phase_next = PH_SP_LOW;
                            default:   phase_next = PH_RD_PREP;
                        endcase
                    end
                end
                PH_RS_HIGH: begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    phase_next = PH_RS_SDA;
                end
                PH_RS_SDA: begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b0;
                    phase_next = PH_RS_SCL;
                end
                PH_RS_SCL: begin
                    scl_next        = 1'b0;
                    sda_next        = 1'b0;
                    shift_byte_next = cmd_device_reg + 8'd1;
                    bit_count_next  = '0;
                    phase_next      = PH_D1_LOW;
                end
                PH_RD_PREP: begin
                    scl_next        = 1'b0;
                    sda_next        = 1'b1;
                    shift_byte_next = '0;
                    bit_count_next  = '0;
                    phase_next      = PH_RD_HIGH;
                end
                PH_RD_HIGH, PH_NACK_HIGH: begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    phase_next = phase_t'(phase_reg + 5'd1);
                end
                PH_RD_SAMPLE: begin
                    shift_byte_next = {shift_byte_reg[6:0], item.sda_level};
                    scl_next        = 1'b0;
                    sda_next        = 1'b1;
                    bit_count_next  = bit_count_reg + 4'd1;
                    phase_next      = (bit_count_next >= BITS_PER_BYTE) ? PH_NACK_HIGH
                                                                        : PH_RD_HIGH;
                end
                PH_NACK_LOW: begin
                    scl_next   = 1'b0;
                    sda_next   = 1'b1;
                    phase_next = PH_SP_LOW;
                end
                PH_SP_LOW: begin
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                    phase_next = PH_SP_SCL;
                end
                PH_SP_SCL: begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b0;
                    phase_next = PH_SP_SDA;
                end
                PH_SP_SDA: begin
                    scl_next       = 1'b1;
                    sda_next       = 1'b1;
                    received_next  = cmd_read_reg ? shift_byte_reg : received_reg;
                    bit_count_next = '0;
                    phase_next     = PH_IDLE;
                    done           = 1'b1;
                end
                default: begin
                end
            endcase
        end else if (ctrl.accept && phase_reg == PH_IDLE &&
                     (item.opcode == OP_WRITE || item.opcode == OP_READ)) begin
            cmd_read_next     = (item.opcode == OP_READ);
            cmd_device_next   = item.device_byte;
            cmd_register_next = item.register_address;
            cmd_data_next     = item.write_data;
            bit_count_next    = '0;
            poll_count_next   = '0;
            scl_next          = 1'b1;
            sda_next          = 1'b1;
            phase_next        = PH_ST_SDA;
        end
    end

    assign result.scl_level     = scl_next;
    assign result.sda_level_out = sda_next;
    assign result.busy_res      = (phase_next != PH_IDLE);
    assign result.done_res      = done;
    assign result.read_data     = received_next;

endmodule

[hdl/i2cra_out_stage.sv]
// ----------------------------------------------------------------------------
// I2C register access master: result register
// Holds one result until the receiver takes it; can load the next one in the cycle it is taken.
// ----------------------------------------------------------------------------
module i2cra_out_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  i2cra_pkg::out_item_t load_data,
    output logic                 can_load,
    output logic                 m_valid,
    input  logic                 m_ready,
    output i2cra_pkg::out_item_t m_data
);
    import i2cra_pkg::*;

    logic      valid_reg, valid_next;
    out_item_t data_reg, data_next;

    assign can_load   = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);
    assign data_next  = load ? load_data : data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

[hdl/i2c_register_access_master.sv]
// ----------------------------------------------------------------------------
// I2C register access master
// Runs one register write or read on an I2C bus, one half-bit per tick.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry requests: a write or read command, or a
//   half-bit tick with the sampled SDA level. Commands while busy are ignored.
//   m_valid/m_ready/m_data carry one result per request: the SCL and SDA pin
//   levels to drive, busy, done on the tick that finishes the stop condition,
//   and the byte from the last finished read.
//   cfg_valid/cfg_ready/cfg_wdata write the acknowledge poll limit; write it
//   only while no request is outstanding. cfg_ready is always high.
// Timing:
//   A result appears in the cycle after its request is accepted. One request
//   is accepted per cycle while s_ready is high; the sequencer step is a
//   single pass of logic between the bus state and result registers.
// Reset and stall:
//   Reset returns to idle with both pins released and the limit at 255.
//   While a result waits in the result register, s_ready stays high only
//   if m_ready is high in that cycle, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module i2c_register_access_master (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  i2cra_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output i2cra_pkg::out_item_t m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           cfg_wdata
);
    import i2cra_pkg::*;

    `include "i2c_register_access_master_defines.svh"

    logic [7:0] limit_reg, limit_next;
    seq_ctrl_t  ctrl;
    out_item_t  step_result;
    logic       can_load;
    logic       accept;

    assign cfg_ready  = 1'b1;
    assign limit_next = (cfg_valid && cfg_ready) ? cfg_wdata : limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= ACK_POLL_LIMIT_RESET;
        end else begin
            limit_reg <= limit_next;
        end
    end

    assign s_ready = can_load;
    assign accept  = s_valid && can_load;

    assign ctrl.accept         = accept;
    assign ctrl.ack_poll_limit = limit_reg;

    i2cra_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .item    (s_data),
        .result  (step_result)
    );

    i2cra_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (accept),
        .load_data (step_result),
        .can_load  (can_load),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    `I2CRA_ASSERT_NEXT(a_accept_gives_result, aclk, aresetn, s_valid && s_ready, m_valid)
    `I2CRA_ASSERT_SAME(a_done_not_busy, aclk, aresetn, m_valid && m_data.done_res, !m_data.busy_res)
    `I2CRA_ASSERT_SAME(a_done_pins_released, aclk, aresetn, m_valid && m_data.done_res, m_data.scl_level && m_data.sda_level_out)

endmodule
